// ===== rtl/core/spc_pkg.sv =====
`timescale 1ns / 1ps
// spc_pkg: shared types and constants for the screen pixel compositor
// no dependencies; used by spc_blend and screen_pixel_compositor

package spc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_BASE_FMT = 2'd0;
  localparam logic [1:0] CFG_IDX_OVL_EN   = 2'd1;

  // base pixel formats
  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_BGR888 = 1'b1;

  // alpha limits and the rounding term of the mix sum
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [15:0] MIX_ROUND   = 16'd127;

  // per-item action of one blend unit
  localparam logic [1:0] MODE_KEEP    = 2'd0;
  localparam logic [1:0] MODE_REPLACE = 2'd1;
  localparam logic [1:0] MODE_MIX     = 2'd2;

  // payload carried alongside the first blend unit for the second layer
  typedef struct packed {
    logic        en;
    logic [31:0] px;
  } carry_t;

endpackage

// ===== rtl/core/spc_blend.sv =====
`timescale 1ns / 1ps
// spc_blend: two-stage alpha-over unit for one overlay layer
// depends on spc_pkg

module spc_blend (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_en,
  input  logic [23:0]         in_dst,
  input  logic [31:0]         in_ov,
  input  spc_pkg::carry_t     in_carry,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [23:0]         out_dst,
  output spc_pkg::carry_t     out_carry
);

  logic             ready_a;
  logic             ready_b;
  logic [7:0]       alpha;
  logic [7:0]       alpha_inv;
  logic [1:0]       mode_nxt;
  logic [15:0]      sum_nxt [3];
  logic [7:0]       quot [3];
  logic [15:0]      div_sum [3];
  logic [23:0]      mix_rgb;

  logic             valid_a_r;
  logic [1:0]       mode_r;
  logic [23:0]      pass_r;
  logic [15:0]      sum_r [3];
  spc_pkg::carry_t  carry_a_r;

  logic             valid_b_r;
  logic [23:0]      dst_b_r;
  spc_pkg::carry_t  carry_b_r;

  // stage handshake: a stage moves when it is empty or its successor takes
  assign ready_b  = !valid_b_r || !out_stall;
  assign ready_a  = !valid_a_r || ready_b;
  assign in_stall = !ready_a;

  // stage a: choose the action and form the weighted channel sums
  assign alpha     = in_ov[31:24];
  assign alpha_inv = spc_pkg::ALPHA_OPAQUE - alpha;

  always_comb begin
    if (!in_en || alpha == spc_pkg::ALPHA_CLEAR) begin
      mode_nxt = spc_pkg::MODE_KEEP;
    end else if (alpha == spc_pkg::ALPHA_OPAQUE) begin
      mode_nxt = spc_pkg::MODE_REPLACE;
    end else begin
      mode_nxt = spc_pkg::MODE_MIX;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = 16'(in_ov[c*8 +: 8]) * 16'(alpha)
                   + 16'(in_dst[c*8 +: 8]) * 16'(alpha_inv)
                   + spc_pkg::MIX_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (ready_a) begin
      valid_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      mode_r    <= mode_nxt;
      pass_r    <= (mode_nxt == spc_pkg::MODE_REPLACE) ? in_ov[23:0] : in_dst;
      sum_r     <= sum_nxt;
      carry_a_r <= in_carry;
    end
  end

  // stage b: divide by 255 as (x + (x >> 8) + 1) >> 8, exact below 255 * 256
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      div_sum[c] = sum_r[c] + {8'd0, sum_r[c][15:8]} + 16'd1;
      quot[c]    = div_sum[c][15:8];
    end
  end

  assign mix_rgb = {quot[2], quot[1], quot[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (ready_b) begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      dst_b_r   <= (mode_r == spc_pkg::MODE_MIX) ? mix_rgb : pass_r;
      carry_b_r <= carry_a_r;
    end
  end

  assign out_valid = valid_b_r;
  assign out_dst   = dst_b_r;
  assign out_carry = carry_b_r;

  // a taken transaction always lands in stage a
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_a_r)
    else $error("spc_blend: accepted transaction lost at stage a");

  // stage a drains into stage b whenever stage b can take it
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_a_r && ready_b |=> valid_b_r)
    else $error("spc_blend: stage a transaction not moved to stage b");

  // a kept or replaced pixel passes through unchanged
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_a_r && ready_b && mode_r != spc_pkg::MODE_MIX |=> dst_b_r == $past(pass_r))
    else $error("spc_blend: pass-through pixel altered");

  // back-pressure only when both stages are full
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> valid_a_r && valid_b_r && out_stall)
    else $error("spc_blend: stall raised with room in the pipeline");

endmodule

// ===== rtl/core/screen_pixel_compositor.sv =====
`timescale 1ns / 1ps
// screen_pixel_compositor: top level, base widening stage and two blend units
// depends on spc_pkg and spc_blend
//
// Usage
//   Input channel (in_valid / in_stall) carries one screen pixel per
//   transaction: the base pixel plus top and system layer ARGB pixels.
//   Output channel (out_valid / out_stall) returns one RGB888 pixel per
//   input transaction, in order.
//   Configuration channel (cfg_valid / cfg_ready) writes base_format
//   (index 0) and overlay_enables (index 1); cfg_ready is always high and
//   writes to other indexes are dropped. Write only while the pipe is empty.
// Timing
//   Five register stages: base widening, then multiply and divide stages
//   for the top layer and again for the system layer; throughput is one
//   pixel per cycle while out_stall is low.
// Reset and stall
//   rst_n (synchronous, active low) empties the pipe and clears both
//   registers. When out_stall is high, items close up behind the output
//   register; in_stall rises only once every stage is full.

module screen_pixel_compositor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_base_pixel,
  input  logic [31:0] in_top_pixel,
  input  logic [31:0] in_sys_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_color_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  logic             base_format_r;
  logic [1:0]       overlay_enables_r;

  logic [23:0]      wide_rgb;
  logic             ready_s1;
  logic             top_stall;
  logic             sys_stall;

  logic             valid_s1_r;
  logic [23:0]      rgb_s1_r;
  logic [31:0]      top_s1_r;
  logic             top_en_s1_r;
  spc_pkg::carry_t  carry_s1_r;

  logic             top_valid;
  logic [23:0]      top_dst;
  spc_pkg::carry_t  top_carry;
  spc_pkg::carry_t  sys_carry;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_format_r     <= 1'b0;
      overlay_enables_r <= 2'b00;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spc_pkg::CFG_IDX_BASE_FMT: base_format_r     <= cfg_data[0];
        spc_pkg::CFG_IDX_OVL_EN:   overlay_enables_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // base widening: rgb565 by bit replication, or bgr888 byte swap
  always_comb begin
    if (base_format_r == spc_pkg::FMT_BGR888) begin
      wide_rgb = {in_base_pixel[7:0], in_base_pixel[15:8], in_base_pixel[23:16]};
    end else begin
      wide_rgb = {in_base_pixel[15:11], in_base_pixel[15:13],
                  in_base_pixel[10:5],  in_base_pixel[10:9],
                  in_base_pixel[4:0],   in_base_pixel[4:2]};
    end
  end

  // stage 1 register
  assign ready_s1 = !valid_s1_r || !top_stall;
  assign in_stall = !ready_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_s1_r <= 1'b0;
    end else if (ready_s1) begin
      valid_s1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_s1) begin
      rgb_s1_r      <= wide_rgb;
      top_s1_r      <= in_top_pixel;
      top_en_s1_r   <= overlay_enables_r[0];
      carry_s1_r.en <= overlay_enables_r[1];
      carry_s1_r.px <= in_sys_pixel;
    end
  end

  // top layer blend
  spc_blend u_top_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (valid_s1_r),
    .in_stall  (top_stall),
    .in_en     (top_en_s1_r),
    .in_dst    (rgb_s1_r),
    .in_ov     (top_s1_r),
    .in_carry  (carry_s1_r),
    .out_valid (top_valid),
    .out_stall (sys_stall),
    .out_dst   (top_dst),
    .out_carry (top_carry)
  );

  // system layer blend, its output register drives the result channel
  assign sys_carry = '0;

  spc_blend u_sys_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (top_valid),
    .in_stall  (sys_stall),
    .in_en     (top_carry.en),
    .in_dst    (top_dst),
    .in_ov     (top_carry.px),
    .in_carry  (sys_carry),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_dst   (out_color_out),
    .out_carry ()
  );

endmodule
